// File: rtl/ps2md_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_pkg
// Shared constants, codes and types of the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_EN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_WHEEL = 3'd6;
    localparam int CFG_DATA_W = 8;

    // field widths
    localparam int COLS_W  = 8;
    localparam int ROWS_W  = 8;
    localparam int GW_W    = 6;
    localparam int GH_W    = 7;
    localparam int PX_W    = COLS_W + GW_W;
    localparam int PY_W    = ROWS_W + GH_W;
    localparam int CELL_W  = 8;
    localparam int POS_W   = 9;
    localparam int CODE_W  = 7;
    localparam int KIND_W  = 2;
    localparam int LINES_W = 3;
    localparam int DELTA_W = 9;
    localparam int SUM_W   = 17;

    // reset values of the configuration registers
    localparam logic [COLS_W-1:0] RST_COLUMNS = 8'd80;
    localparam logic [ROWS_W-1:0] RST_ROWS    = 8'd25;
    localparam logic [GW_W-1:0]   RST_GLYPH_W = 6'd8;
    localparam logic [GH_W-1:0]   RST_GLYPH_H = 7'd16;

    // event kinds
    localparam logic [KIND_W-1:0] EV_CURSOR = 2'd0;
    localparam logic [KIND_W-1:0] EV_BUTTON = 2'd1;
    localparam logic [KIND_W-1:0] EV_WHEEL  = 2'd2;
    localparam logic [KIND_W-1:0] EV_SCROLL = 2'd3;

    // button codes
    localparam logic [CODE_W-1:0] BTN_LEFT       = 7'd0;
    localparam logic [CODE_W-1:0] BTN_MIDDLE     = 7'd1;
    localparam logic [CODE_W-1:0] BTN_RIGHT      = 7'd2;
    localparam logic [CODE_W-1:0] BTN_WHEEL_UP   = 7'd64;
    localparam logic [CODE_W-1:0] BTN_WHEEL_DOWN = 7'd65;

    localparam logic signed [LINES_W-1:0] SCROLL_UP   = -3'sd3;
    localparam logic signed [LINES_W-1:0] SCROLL_DOWN = 3'sd3;

    // serial divider sizes
    localparam int DVD_W = PY_W;
    localparam int DVS_W = GH_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: rtl/ps2md_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_in_if
// Byte channel from the PS/2 controller: valid/ready and byte payload.
// ----------------------------------------------------------------------------
interface ps2md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       from_aux;

    modport source (output valid, output rx_byte, output from_aux, input ready);
    modport sink   (input valid, input rx_byte, input from_aux, output ready);
endinterface

// File: rtl/ps2md_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_out_if
// Event channel of the decoder: valid/ready and event payload.
// ----------------------------------------------------------------------------
interface ps2md_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [6:0]        button_code;
    logic [8:0]        cell_col;
    logic [8:0]        cell_row;
    logic              pressed;
    logic signed [2:0] scroll_lines;
    logic              last_event;

    modport source (output valid, output event_kind, output button_code, output cell_col,
                    output cell_row, output pressed, output scroll_lines,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input button_code, input cell_col,
                    input cell_row, input pressed, input scroll_lines,
                    input last_event, output ready);
endinterface

// File: rtl/ps2md_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_div
// Restoring serial divider, one quotient bit per cycle, shared for both axes.
// ----------------------------------------------------------------------------
module ps2md_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ps2md_pkg::DVD_W-1:0] dividend,
    input  logic [ps2md_pkg::DVS_W-1:0] divisor,
    output ps2md_pkg::div_status_t      status,
    output logic [ps2md_pkg::DVD_W-1:0] quotient
);
    import ps2md_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a run");
`endif

endmodule

// File: rtl/ps2md_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2md_ctrl
// Packet assembly, pointer update and event sequencer around the divider.
// ----------------------------------------------------------------------------
module ps2md_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    ps2md_in_if.sink                         rx,
    ps2md_out_if.source                      evt,
    input  logic                             cfg_wr_en,
    input  logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                             div_start,
    output logic [ps2md_pkg::DVD_W-1:0]      div_dividend,
    output logic [ps2md_pkg::DVS_W-1:0]      div_divisor,
    input  ps2md_pkg::div_status_t           div_status,
    input  logic [ps2md_pkg::DVD_W-1:0]      div_quotient
);
    import ps2md_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_DECODE = 4'd1;
    localparam logic [ST_W-1:0] S_GEOM   = 4'd2;
    localparam logic [ST_W-1:0] S_MOVE   = 4'd3;
    localparam logic [ST_W-1:0] S_XSTART = 4'd4;
    localparam logic [ST_W-1:0] S_XWAIT  = 4'd5;
    localparam logic [ST_W-1:0] S_YSTART = 4'd6;
    localparam logic [ST_W-1:0] S_YWAIT  = 4'd7;
    localparam logic [ST_W-1:0] S_EMIT   = 4'd8;

    localparam int PEND_W = 5;
    localparam int P_CURSOR = 0;
    localparam int P_LEFT   = 1;
    localparam int P_RIGHT  = 2;
    localparam int P_MIDDLE = 3;
    localparam int P_WHEEL  = 4;

    // configuration
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [GW_W-1:0]   gw_reg;
    logic [GH_W-1:0]   gh_reg;
    logic              wheel_mode_reg, report_en_reg, report_wheel_reg;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [2:0]        offset_reg, offset_next;
    logic [7:0]        pkt_reg [4];
    logic              pkt_we;
    logic [2:0]        last_btn_reg, last_btn_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PX_W-1:0]   px_reg, px_next;
    logic [PY_W-1:0]   py_reg, py_next;
    logic [CELL_W-1:0] cx_reg, cx_next;
    logic [CELL_W-1:0] cy_reg, cy_next;
    logic [PX_W-1:0]   w_reg, w_next;
    logic [PY_W-1:0]   h_reg, h_next;
    logic signed [DELTA_W-1:0] dx_reg, dx_next;
    logic signed [DELTA_W-1:0] dy_reg, dy_next;

    logic                     ov_reg, ov_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [CODE_W-1:0]        code_reg, code_next;
    logic [POS_W-1:0]         col_reg, col_next;
    logic [POS_W-1:0]         row_reg, row_next;
    logic                     pressed_reg, pressed_next;
    logic signed [LINES_W-1:0] lines_reg, lines_next;
    logic                     last_reg, last_next;

    logic [2:0]        offset_inc;
    logic [2:0]        pkt_len;
    logic [7:0]        b0;
    logic [2:0]        btn;
    logic [2:0]        changed;
    logic [3:0]        zval;
    logic              geom_ok;
    logic signed [SUM_W-1:0] sx, sy;
    logic [PEND_W-1:0] sel;
    logic [PEND_W-1:0] rest;

    assign rx.ready   = (state_reg == S_IDLE);
    assign offset_inc = offset_reg + 3'd1;
    assign pkt_len    = wheel_mode_reg ? 3'd4 : 3'd3;
    assign b0         = pkt_reg[0];
    assign btn        = b0[2:0];
    assign changed    = btn ^ last_btn_reg;
    assign zval       = pkt_reg[3][3:0];
    assign geom_ok    = (cols_reg != '0) && (rows_reg != '0) && (gw_reg != '0)
                        && (gh_reg != '0);
    assign sx = $signed({{(SUM_W-PX_W){1'b0}}, px_reg})
                + {{(SUM_W-DELTA_W){dx_reg[DELTA_W-1]}}, dx_reg};
    assign sy = $signed({{(SUM_W-PY_W){1'b0}}, py_reg})
                - {{(SUM_W-DELTA_W){dy_reg[DELTA_W-1]}}, dy_reg};
    assign sel  = pend_reg & (~pend_reg + PEND_W'(1));
    assign rest = pend_reg & ~sel;

    assign div_start    = (state_reg == S_XSTART) || (state_reg == S_YSTART);
    assign div_dividend = (state_reg == S_XSTART) ? DVD_W'(px_reg) : py_reg;
    assign div_divisor  = (state_reg == S_XSTART) ? DVS_W'(gw_reg) : gh_reg;

    always_comb
    begin
        state_next    = state_reg;
        offset_next   = offset_reg;
        pkt_we        = 1'b0;
        last_btn_next = last_btn_reg;
        pend_next     = pend_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        ov_next       = ov_reg;
        kind_next     = kind_reg;
        code_next     = code_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pressed_next  = pressed_reg;
        lines_next    = lines_reg;
        last_next     = last_reg;

        if (ov_reg && evt.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (rx.valid && rx.from_aux)
                begin
                    if (offset_reg == 3'd0 && !rx.rx_byte[3])
                    begin
                        offset_next = offset_reg;
                    end
                    else if (offset_reg >= 3'd4)
                    begin
                        offset_next = 3'd0;
                    end
                    else
                    begin
                        pkt_we = 1'b1;
                        if (offset_inc < pkt_len)
                        begin
                            offset_next = offset_inc;
                        end
                        else
                        begin
                            offset_next = 3'd0;
                            state_next  = S_DECODE;
                        end
                    end
                end
            end
            S_DECODE:
            begin
                if (b0[7:6] != 2'b00)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    dx_next = {b0[4], pkt_reg[1]};
                    dy_next = {b0[5], pkt_reg[2]};
                    pend_next[P_CURSOR] = geom_ok
                        && ((b0[4] || pkt_reg[1] != 8'd0) || (b0[5] || pkt_reg[2] != 8'd0));
                    pend_next[P_LEFT]   = report_en_reg && changed[0];
                    pend_next[P_RIGHT]  = report_en_reg && changed[1];
                    pend_next[P_MIDDLE] = report_en_reg && changed[2];
                    pend_next[P_WHEEL]  = wheel_mode_reg && (zval != 4'd0);
                    last_btn_next = btn;
                    if (pend_next[P_CURSOR])
                    begin
                        state_next = S_GEOM;
                    end
                    else if (pend_next != '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_GEOM:
            begin
                w_next     = PX_W'(cols_reg) * PX_W'(gw_reg);
                h_next     = PY_W'(rows_reg) * PY_W'(gh_reg);
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (sx < 0)
                begin
                    px_next = '0;
                end
                else if (sx >= $signed({{(SUM_W-PX_W){1'b0}}, w_reg}))
                begin
                    px_next = w_reg - PX_W'(1);
                end
                else
                begin
                    px_next = sx[PX_W-1:0];
                end
                if (sy < 0)
                begin
                    py_next = '0;
                end
                else if (sy >= $signed({{(SUM_W-PY_W){1'b0}}, h_reg}))
                begin
                    py_next = h_reg - PY_W'(1);
                end
                else
                begin
                    py_next = sy[PY_W-1:0];
                end
                state_next = S_XSTART;
            end
            S_XSTART:
            begin
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (div_status.done)
                begin
                    cx_next    = div_quotient[CELL_W-1:0];
                    state_next = S_YSTART;
                end
            end
            S_YSTART:
            begin
                state_next = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (div_status.done)
                begin
                    cy_next    = div_quotient[CELL_W-1:0];
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || evt.ready)
                begin
                    ov_next      = 1'b1;
                    kind_next    = EV_CURSOR;
                    code_next    = BTN_LEFT;
                    col_next     = POS_W'(cx_reg) + POS_W'(1);
                    row_next     = POS_W'(cy_reg) + POS_W'(1);
                    pressed_next = 1'b0;
                    lines_next   = '0;
                    last_next    = (rest == '0);
                    if (sel[P_LEFT])
                    begin
                        kind_next    = EV_BUTTON;
                        code_next    = BTN_LEFT;
                        pressed_next = last_btn_reg[0];
                    end
                    else if (sel[P_RIGHT])
                    begin
                        kind_next    = EV_BUTTON;
                        code_next    = BTN_RIGHT;
                        pressed_next = last_btn_reg[1];
                    end
                    else if (sel[P_MIDDLE])
                    begin
                        kind_next    = EV_BUTTON;
                        code_next    = BTN_MIDDLE;
                        pressed_next = last_btn_reg[2];
                    end
                    else if (sel[P_WHEEL])
                    begin
                        if (report_en_reg && report_wheel_reg)
                        begin
                            kind_next    = EV_WHEEL;
                            code_next    = zval[3] ? BTN_WHEEL_DOWN : BTN_WHEEL_UP;
                            pressed_next = 1'b1;
                        end
                        else
                        begin
                            kind_next  = EV_SCROLL;
                            lines_next = zval[3] ? SCROLL_DOWN : SCROLL_UP;
                        end
                    end
                    pend_next = rest;
                    if (rest == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            offset_reg       <= '0;
            last_btn_reg     <= '0;
            pend_reg         <= '0;
            px_reg           <= '0;
            py_reg           <= '0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            ov_reg           <= 1'b0;
            cols_reg         <= RST_COLUMNS;
            rows_reg         <= RST_ROWS;
            gw_reg           <= RST_GLYPH_W;
            gh_reg           <= RST_GLYPH_H;
            wheel_mode_reg   <= 1'b0;
            report_en_reg    <= 1'b0;
            report_wheel_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            offset_reg   <= offset_next;
            last_btn_reg <= last_btn_next;
            pend_reg     <= pend_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            ov_reg       <= ov_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_COLUMNS:      cols_reg         <= cfg_data[COLS_W-1:0];
                    REG_ROWS:         rows_reg         <= cfg_data[ROWS_W-1:0];
                    REG_GLYPH_W:      gw_reg           <= cfg_data[GW_W-1:0];
                    REG_GLYPH_H:      gh_reg           <= cfg_data[GH_W-1:0];
                    REG_WHEEL_MODE:   wheel_mode_reg   <= cfg_data[0];
                    REG_REPORT_EN:    report_en_reg    <= cfg_data[0];
                    REG_REPORT_WHEEL: report_wheel_reg <= cfg_data[0];
                    default:          cols_reg         <= cols_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_we)
        begin
            pkt_reg[offset_reg[1:0]] <= rx.rx_byte;
        end
        w_reg       <= w_next;
        h_reg       <= h_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        kind_reg    <= kind_next;
        code_reg    <= code_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        pressed_reg <= pressed_next;
        lines_reg   <= lines_next;
        last_reg    <= last_next;
    end

    assign evt.valid        = ov_reg;
    assign evt.event_kind   = kind_reg;
    assign evt.button_code  = code_reg;
    assign evt.cell_col     = col_reg;
    assign evt.cell_row     = row_reg;
    assign evt.pressed      = pressed_reg;
    assign evt.scroll_lines = lines_reg;
    assign evt.last_event   = last_reg;

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_XWAIT || state_reg == S_YWAIT))
        else $error("divider result with nobody waiting");
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pend_reg != '0))
        else $error("event sequencer with nothing pending");
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < 3'd4)
        else $error("packet offset beyond buffer");
`endif

endmodule

// File: rtl/ps2_mouse_packet_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_unit
// PS/2 mouse packet decoder: packet sync, pointer tracking, cell lookup and
// cursor, button, wheel and scrollback events.
//
//   channel | dir | handshake     | payload
//   rx      | in  | valid/ready   | rx_byte, from_aux
//   evt     | out | valid/ready   | event_kind, button_code, cell_col, cell_row,
//           |     |               | pressed, scroll_lines, last_event
//   cfg     | in  | cfg_wr_en     | cfg_index, cfg_data
//
// each packet byte is taken in S_IDLE; a closing byte moves to S_DECODE and, with
// motion, through S_GEOM and S_MOVE for the clamp and two 15-step divisions on the
// shared serial divider; rx is not taken again until the sequencer, at one event
// per cycle unless evt stalls, has emitted the last pending event
// no clearing pass after reset; rx.ready is high as soon as reset is released
// the last event of a packet may wait in the output register while rx is taken
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    ps2md_in_if.sink                         rx,
    ps2md_out_if.source                      evt,
    input  logic                             cfg_wr_en,
    input  logic [ps2md_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2md_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ps2md_pkg::*;

    logic        div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    div_status_t div_status;
    logic [DVD_W-1:0] div_quotient;

    ps2md_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx           (rx),
        .evt          (evt),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_status   (div_status),
        .div_quotient (div_quotient)
    );

    ps2md_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

endmodule
